// ----- design/base64_stream_encoder_assert.svh -----
// Assertion macros shared by the Base64 stream encoder modules.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64E_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B64E_ASSERT_IMPLY(lbl, ante, cons, msg)
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/b64e_pkg.sv -----
// Types, constants and the alphabet function of the Base64 stream encoder.
package b64e_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] CharUpperA = 7'h41;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharPlus   = 7'h2B;
  localparam logic [6:0] CharSlash  = 7'h2F;
  localparam logic [6:0] CharPad    = 7'h3D;

  localparam logic [5:0] IdxLower = 6'd26;
  localparam logic [5:0] IdxDigit = 6'd52;
  localparam logic [5:0] IdxPlus  = 6'd62;

  typedef enum logic [1:0] {
    GK_FULL,
    GK_ONE_BYTE,
    GK_TWO_BYTES
  } group_kind_e;

  typedef struct packed {
    logic [23:0] word;
    group_kind_e kind;
    logic        last;
  } group_t;

  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] c;
    if (idx < IdxLower) begin
      c = CharUpperA + {1'b0, idx};
    end else if (idx < IdxDigit) begin
      c = CharLowerA + {1'b0, idx - IdxLower};
    end else if (idx < IdxPlus) begin
      c = CharZero + {1'b0, idx - IdxDigit};
    end else if (idx == IdxPlus) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

endpackage

// ----- design/b64e_front.sv -----
// Front end: gathers message bytes into groups of three and classifies each group.
module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_message_i,
  output logic             grp_wr_o,
  output b64e_pkg::group_t grp_o
);

  logic [1:0]  pos_q, pos_d;
  logic [15:0] pend_q, pend_d;

  always_comb begin
    pos_d        = pos_q;
    pend_d       = pend_q;
    grp_wr_o     = 1'b0;
    grp_o.word   = {in_byte_i, 16'h0000};
    grp_o.kind   = b64e_pkg::GK_ONE_BYTE;
    grp_o.last   = end_of_message_i;
    case (pos_q)
      2'd1: begin
        grp_o.word = {pend_q[15:8], in_byte_i, 8'h00};
        grp_o.kind = b64e_pkg::GK_TWO_BYTES;
      end
      2'd2: begin
        grp_o.word = {pend_q, in_byte_i};
        grp_o.kind = b64e_pkg::GK_FULL;
      end
      default: begin
        grp_o.word = {in_byte_i, 16'h0000};
        grp_o.kind = b64e_pkg::GK_ONE_BYTE;
      end
    endcase
    if (accept_i) begin
      if (pos_q == 2'd2 || end_of_message_i) begin
        grp_wr_o = 1'b1;
        pos_d    = 2'd0;
      end else if (pos_q == 2'd1) begin
        pend_d = {pend_q[15:8], in_byte_i};
        pos_d  = 2'd2;
      end else begin
        pend_d = {in_byte_i, 8'h00};
        pos_d  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      pend_q <= 16'h0000;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ----- design/b64e_fifo.sv -----
// Short queue of classified groups between the front and back ends.
`include "base64_stream_encoder_assert.svh"
module b64e_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  b64e_pkg::group_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output b64e_pkg::group_t rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = b64e_pkg::QPtrW;
  localparam int unsigned CntW = b64e_pkg::QCntW;
  localparam logic [CntW-1:0] DepthC = CntW'(b64e_pkg::QDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(b64e_pkg::QDepth - 1);

  b64e_pkg::group_t mem_q [b64e_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == DepthC);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `B64E_ASSERT_IMPLY(a_no_overflow, wr_i, !full_o, "Group written into a full queue.")
  `B64E_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q <= DepthC, "Queue count out of range.")

endmodule

// ----- design/b64e_back.sv -----
// Back end: turns each queued group into four characters, one per cycle unless pop stalls the output.
`include "base64_stream_encoder_assert.svh"
module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             grp_empty_i,
  input  b64e_pkg::group_t grp_i,
  output logic             grp_rd_o,
  output logic             empty,
  input  logic             pop,
  output logic [6:0]       out_char_o,
  output logic             last_char_o
);

  b64e_pkg::group_t g_q;
  logic             g_vld_q, g_vld_d;
  logic [1:0]       k_q, k_d;
  logic             out_vld_q, out_vld_d;
  logic [6:0]       out_char_q;
  logic             out_last_q;
  logic             adv, last_k, take, pad;
  logic [5:0]       idx;
  logic [6:0]       ch;

  assign adv    = g_vld_q && (!out_vld_q || pop);
  assign last_k = (k_q == 2'd3);
  assign take   = !grp_empty_i && (!g_vld_q || (adv && last_k));

  always_comb begin
    case (k_q)
      2'd0:    idx = g_q.word[23:18];
      2'd1:    idx = g_q.word[17:12];
      2'd2:    idx = g_q.word[11:6];
      default: idx = g_q.word[5:0];
    endcase
    pad = ((g_q.kind == b64e_pkg::GK_ONE_BYTE) && k_q[1]) ||
          ((g_q.kind == b64e_pkg::GK_TWO_BYTES) && last_k);
    ch  = pad ? b64e_pkg::CharPad : b64e_pkg::b64_char(idx);
  end

  always_comb begin
    g_vld_d = g_vld_q;
    if (take) begin
      g_vld_d = 1'b1;
    end else if (adv && last_k) begin
      g_vld_d = 1'b0;
    end
    k_d       = adv ? k_q + 2'd1 : k_q;
    out_vld_d = adv ? 1'b1 : (pop ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q   <= 1'b0;
      k_q       <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      g_vld_q   <= g_vld_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      g_q <= grp_i;
    end
    if (adv) begin
      out_char_q <= ch;
      out_last_q <= last_k && g_q.last;
    end
  end

  assign grp_rd_o    = take;
  assign empty       = !out_vld_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

  `B64E_ASSERT_IMPLY(a_idle_at_start, k_q != 2'd0, g_vld_q,
                     "Character position advanced without a group.")
  `B64E_ASSERT_NEXT(a_group_retires, adv && last_k && !take, !g_vld_q,
                    "Group kept after its fourth character.")

endmodule

// ----- design/base64_stream_encoder.sv -----
// Top level of the Base64 stream encoder.
// Accepts one message byte per cycle while full is low and emits one Base64
// character per cycle while the consumer pops (RFC 4648 alphabet, '=' padding),
// with last_char_o on the final character of each message. A byte that ends a
// group of three or ends the message places one group in a two-entry queue; the
// back end turns each group into four characters, so sustained throughput is set
// by the single character output. full is high while the group queue holds two
// groups. A group passes through the queue, the back end's group register and its
// character register. Every message holds at least one byte.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_message_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       last_char_o
);

  b64e_pkg::group_t wr_grp, rd_grp;
  logic             grp_wr, grp_rd, q_full, q_empty, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .grp_wr_o         (grp_wr),
    .grp_o            (wr_grp)
  );

  b64e_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_wr),
    .wr_data_i (wr_grp),
    .full_o    (q_full),
    .rd_i      (grp_rd),
    .rd_data_o (rd_grp),
    .empty_o   (q_empty)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_empty_i (q_empty),
    .grp_i       (rd_grp),
    .grp_rd_o    (grp_rd),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
